>>> rtl/plhr_pkg.sv
// Shared types and constants for the piecewise linear height remap pipeline.
`timescale 1ns / 1ps

package plhr_pkg;

  localparam int unsigned RegW   = 16;  // configuration register and sample width
  localparam int unsigned IdxW   = 3;   // configuration register index width
  localparam int unsigned PosW   = 18;  // signed breakpoints and knots
  localparam int unsigned SpanW  = 16;  // segment span and offset into segment
  localparam int unsigned QuotW  = 17;  // quotient magnitude, also divider depth
  localparam int unsigned ProdW  = SpanW + QuotW;
  localparam int unsigned OutW   = 18;

  localparam logic [IdxW-1:0] RegInSeaLevel      = 3'd0;
  localparam logic [IdxW-1:0] RegInMountainLevel = 3'd1;
  localparam logic [IdxW-1:0] RegOutSeaBottom    = 3'd2;
  localparam logic [IdxW-1:0] RegOutSeaLevel     = 3'd3;
  localparam logic [IdxW-1:0] RegOutMountainBase = 3'd4;
  localparam logic [IdxW-1:0] RegOutMountainTop  = 3'd5;

  localparam logic [RegW-1:0] RstInSeaLevel      = 16'd24576;
  localparam logic [RegW-1:0] RstInMountainLevel = 16'd40960;
  localparam logic [RegW-1:0] RstOutSeaBottom    = 16'd8192;
  localparam logic [RegW-1:0] RstOutSeaLevel     = 16'd16384;
  localparam logic [RegW-1:0] RstOutMountainBase = 16'd24576;
  localparam logic [RegW-1:0] RstOutMountainTop  = 16'd49152;

  localparam logic signed [PosW-1:0] InStepBelow  = 18'sd512;
  localparam logic signed [PosW-1:0] InStepAbove  = 18'sd512;
  localparam logic signed [PosW-1:0] OutStepBelow = 18'sd1280;
  localparam logic signed [PosW-1:0] OutStepAbove = 18'sd1024;
  localparam logic signed [PosW-1:0] InTop        = 18'sd65280;

  typedef struct packed {
    logic [RegW-1:0] in_sea_level;
    logic [RegW-1:0] in_mountain_level;
    logic [RegW-1:0] out_sea_bottom;
    logic [RegW-1:0] out_sea_level;
    logic [RegW-1:0] out_mountain_base;
    logic [RegW-1:0] out_mountain_top;
  } plhr_cfg_t;

  // Per-item sideband that rides along the divider.
  typedef struct packed {
    logic                   hit;
    logic                   neg;
    logic signed [PosW-1:0] y_lo;
  } plhr_side_t;

endpackage

>>> rtl/plhr_segment.sv
// Segment select, segment parameters and offset times rise: three pipeline stages.
`timescale 1ns / 1ps

module plhr_segment (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  plhr_pkg::plhr_cfg_t         cfg_i,
  input  logic                        valid_i,
  input  logic [plhr_pkg::RegW-1:0]   sample_i,
  output logic                        valid_o,
  output logic [plhr_pkg::ProdW-1:0]  prod_o,
  output logic [plhr_pkg::SpanW-1:0]  span_o,
  output plhr_pkg::plhr_side_t        side_o
);

  localparam int unsigned PosW = plhr_pkg::PosW;

  // Breakpoints and knots
  logic signed [PosW-1:0] x1, x2, x3, x4;
  logic signed [PosW-1:0] y0, y1, y2, y3, y4, y5;

  assign x2 = $signed({2'b00, cfg_i.in_sea_level});
  assign x1 = x2 - plhr_pkg::InStepBelow;
  assign x3 = x2 + plhr_pkg::InStepAbove;
  assign x4 = $signed({2'b00, cfg_i.in_mountain_level});

  assign y0 = $signed({2'b00, cfg_i.out_sea_bottom});
  assign y2 = $signed({2'b00, cfg_i.out_sea_level});
  assign y1 = y2 - plhr_pkg::OutStepBelow;
  assign y3 = y2 + plhr_pkg::OutStepAbove;
  assign y4 = $signed({2'b00, cfg_i.out_mountain_base});
  assign y5 = $signed({2'b00, cfg_i.out_mountain_top});

  // Stage A: range compares
  logic signed [PosW-1:0] v_s;
  logic [4:0]             hit_d;
  logic                   a_valid_q;
  logic [plhr_pkg::RegW-1:0] a_v_q;
  logic [4:0]             a_hit_q;

  assign v_s = $signed({2'b00, sample_i});

  always_comb begin
    hit_d[0] = (v_s >= 18'sd0) && (v_s < x1);
    hit_d[1] = (v_s >= x1) && (v_s < x2);
    hit_d[2] = (v_s >= x2) && (v_s < x3);
    hit_d[3] = (v_s >= x3) && (v_s < x4);
    hit_d[4] = (v_s >= x4) && (v_s < plhr_pkg::InTop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_v_q   <= sample_i;
      a_hit_q <= hit_d;
    end
  end

  // Stage B: pick the first matching segment, form offset, span and rise
  logic [2:0]             sel;
  logic                   any_hit;
  logic signed [PosW-1:0] x_lo, x_hi, yl, yh;
  logic signed [PosW-1:0] off_full, span_full, rise, rise_abs;
  logic                   b_valid_q;
  logic [plhr_pkg::SpanW-1:0] b_off_q, b_span_q;
  logic [plhr_pkg::QuotW-1:0] b_mag_q;
  plhr_pkg::plhr_side_t   b_side_q;

  always_comb begin
    sel     = 3'd0;
    any_hit = 1'b0;
    for (int j = 4; j >= 0; j--) begin
      if (a_hit_q[j]) begin
        sel     = 3'(j);
        any_hit = 1'b1;
      end
    end
  end

  always_comb begin
    case (sel)
      3'd0: begin
        x_lo = 18'sd0; x_hi = x1; yl = y0; yh = y1;
      end
      3'd1: begin
        x_lo = x1; x_hi = x2; yl = y1; yh = y2;
      end
      3'd2: begin
        x_lo = x2; x_hi = x3; yl = y2; yh = y3;
      end
      3'd3: begin
        x_lo = x3; x_hi = x4; yl = y3; yh = y4;
      end
      default: begin
        x_lo = x4; x_hi = plhr_pkg::InTop; yl = y4; yh = y5;
      end
    endcase
  end

  assign off_full  = $signed({2'b00, a_v_q}) - x_lo;
  assign span_full = x_hi - x_lo;
  assign rise      = yh - yl;
  assign rise_abs  = rise[PosW-1] ? -rise : rise;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_off_q       <= off_full[plhr_pkg::SpanW-1:0];
      b_span_q      <= span_full[plhr_pkg::SpanW-1:0];
      b_mag_q       <= rise_abs[plhr_pkg::QuotW-1:0];
      b_side_q.hit  <= any_hit;
      b_side_q.neg  <= rise[PosW-1];
      b_side_q.y_lo <= yl;
    end
  end

  // Stage C: offset times rise magnitude
  logic                       c_valid_q;
  logic [plhr_pkg::ProdW-1:0] c_prod_q;
  logic [plhr_pkg::SpanW-1:0] c_span_q;
  plhr_pkg::plhr_side_t       c_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (adv_i) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_prod_q <= plhr_pkg::ProdW'(b_off_q) * plhr_pkg::ProdW'(b_mag_q);
      c_span_q <= b_span_q;
      c_side_q <= b_side_q;
    end
  end

  assign valid_o = c_valid_q;
  assign prod_o  = c_prod_q;
  assign span_o  = c_span_q;
  assign side_o  = c_side_q;

endmodule

>>> rtl/plhr_divider.sv
// Pipelined restoring divider: one quotient bit per stage.
`timescale 1ns / 1ps

module plhr_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  logic [plhr_pkg::ProdW-1:0]  prod_i,
  input  logic [plhr_pkg::SpanW-1:0]  span_i,
  input  plhr_pkg::plhr_side_t        side_i,
  output logic                        valid_o,
  output logic [plhr_pkg::QuotW-1:0]  quot_o,
  output logic [plhr_pkg::SpanW-1:0]  rem_o,
  output logic [plhr_pkg::SpanW-1:0]  span_o,
  output plhr_pkg::plhr_side_t        side_o
);

  localparam int unsigned SpanW = plhr_pkg::SpanW;
  localparam int unsigned QuotW = plhr_pkg::QuotW;

  logic                 vld_q  [QuotW];
  logic [SpanW-1:0]     rem_q  [QuotW];
  logic [QuotW-1:0]     lq_q   [QuotW];  // dividend bits shift out, quotient bits shift in
  logic [SpanW-1:0]     d_q    [QuotW];
  plhr_pkg::plhr_side_t side_q [QuotW];

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic                 vld_in;
    logic [SpanW-1:0]     rem_in;
    logic [QuotW-1:0]     lq_in;
    logic [SpanW-1:0]     d_in;
    plhr_pkg::plhr_side_t side_in;
    logic [SpanW:0]       trial;
    logic [SpanW:0]       diff;
    logic                 ge;

    if (k == 0) begin : g_first
      // quotient fits QuotW bits, so the upper dividend bits are already below the span
      assign vld_in  = valid_i;
      assign rem_in  = prod_i[plhr_pkg::ProdW-1:QuotW];
      assign lq_in   = prod_i[QuotW-1:0];
      assign d_in    = span_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign lq_in   = lq_q[k-1];
      assign d_in    = d_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, lq_in[QuotW-1]};
    assign ge    = trial >= {1'b0, d_in};
    assign diff  = trial - {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k]  <= ge ? diff[SpanW-1:0] : trial[SpanW-1:0];
        lq_q[k]   <= {lq_in[QuotW-2:0], ge};
        d_q[k]    <= d_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QuotW-1];
  assign quot_o  = lq_q[QuotW-1];
  assign rem_o   = rem_q[QuotW-1];
  assign span_o  = d_q[QuotW-1];
  assign side_o  = side_q[QuotW-1];

endmodule

>>> rtl/piecewise_linear_height_remap.sv
// Top level of the piecewise linear height remap: config registers, pipeline, output register.
`timescale 1ns / 1ps

// Each 16-bit primary height sample is mapped through a five-segment piecewise
// linear curve set by six configuration registers, written through cfg_we_i /
// cfg_index_i / cfg_data_i by the user only while no sample is in flight; the
// block does not enforce this. It takes one sample per cycle unless stalled.
// Stages: one for the segment compares, one for the segment parameters, one for
// the offset times rise product, seventeen for the divider (one quotient bit per
// stage) and the output register. A stalled output freezes the whole pipeline;
// in_stall_o is high exactly while a result waits and out_stall_i is high.
// Results come out in input order; a sample outside every segment yields zero.

module piecewise_linear_height_remap (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [plhr_pkg::IdxW-1:0]          cfg_index_i,
  input  logic [plhr_pkg::RegW-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [plhr_pkg::RegW-1:0]          primary_height_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [plhr_pkg::OutW-1:0]   mapped_height_o
);

  plhr_pkg::plhr_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_sea_level      <= plhr_pkg::RstInSeaLevel;
      cfg_q.in_mountain_level <= plhr_pkg::RstInMountainLevel;
      cfg_q.out_sea_bottom    <= plhr_pkg::RstOutSeaBottom;
      cfg_q.out_sea_level     <= plhr_pkg::RstOutSeaLevel;
      cfg_q.out_mountain_base <= plhr_pkg::RstOutMountainBase;
      cfg_q.out_mountain_top  <= plhr_pkg::RstOutMountainTop;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        plhr_pkg::RegInSeaLevel:      cfg_q.in_sea_level      <= cfg_data_i;
        plhr_pkg::RegInMountainLevel: cfg_q.in_mountain_level <= cfg_data_i;
        plhr_pkg::RegOutSeaBottom:    cfg_q.out_sea_bottom    <= cfg_data_i;
        plhr_pkg::RegOutSeaLevel:     cfg_q.out_sea_level     <= cfg_data_i;
        plhr_pkg::RegOutMountainBase: cfg_q.out_mountain_base <= cfg_data_i;
        plhr_pkg::RegOutMountainTop:  cfg_q.out_mountain_top  <= cfg_data_i;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Advance every stage unless a result is held at the output
  logic out_valid_q;
  logic adv;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  logic                         seg_valid;
  logic [plhr_pkg::ProdW-1:0]   seg_prod;
  logic [plhr_pkg::SpanW-1:0]   seg_span;
  plhr_pkg::plhr_side_t         seg_side;

  plhr_segment u_segment (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .cfg_i    (cfg_q),
    .valid_i  (in_valid_i),
    .sample_i (primary_height_i),
    .valid_o  (seg_valid),
    .prod_o   (seg_prod),
    .span_o   (seg_span),
    .side_o   (seg_side)
  );

  logic                         div_valid;
  logic [plhr_pkg::QuotW-1:0]   div_quot;
  logic [plhr_pkg::SpanW-1:0]   div_rem;
  logic [plhr_pkg::SpanW-1:0]   div_span;
  plhr_pkg::plhr_side_t         div_side;

  plhr_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (seg_valid),
    .prod_i  (seg_prod),
    .span_i  (seg_span),
    .side_i  (seg_side),
    .valid_o (div_valid),
    .quot_o  (div_quot),
    .rem_o   (div_rem),
    .span_o  (div_span),
    .side_o  (div_side)
  );

  // Apply the sign of the rise to the truncated quotient and add the lower knot
  logic signed [plhr_pkg::OutW-1:0] quot_s;
  logic signed [plhr_pkg::OutW-1:0] mapped_d;
  logic signed [plhr_pkg::OutW-1:0] mapped_q;

  assign quot_s = $signed({1'b0, div_quot});

  always_comb begin
    if (div_side.hit) begin
      mapped_d = div_side.y_lo + (div_side.neg ? -quot_s : quot_s);
    end else begin
      mapped_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mapped_q <= mapped_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mapped_height_o = mapped_q;

  // A matched segment always has a positive span
  a_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid && seg_side.hit |-> seg_span != '0)
    else $error("matched segment with zero span");

  // The quotient fits the divider: upper product bits lie below the span
  a_quot_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid && seg_side.hit |-> seg_prod[plhr_pkg::ProdW-1:plhr_pkg::QuotW] < seg_span)
    else $error("product too large for quotient width");

  // The final remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid && div_side.hit |-> div_rem < div_span)
    else $error("divider remainder not reduced");

  // A result appears only from a valid divider output
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(div_valid))
    else $error("result without a transaction behind it");

endmodule
